// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int KEY_W        = 16;
  localparam int PRIO_W       = 16;
  localparam int RANK_W       = 8;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_POP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic [KEY_W-1:0]          key;
    logic signed [PRIO_W-1:0]  priority_req;
    logic [RANK_W-1:0]         rank;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic [KEY_W-1:0]          out_key;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [COUNT_W-1:0]        entry_count;
  } out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic [RANK_W-1:0]         rank;
    logic [KEY_W-1:0]          key;
    logic signed [PRIO_W-1:0]  prio;
  } cell_ctl_t;

  // per-cell compare results
  typedef struct packed {
    logic match;
    logic ge;
  } cell_stat_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted list: holds a key and priority, compares against
// the request, and shifts to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int SK  = 16
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occ,
  input  logic                     left_ge,
  input  logic [SK-1:0]            left_key,
  input  logic signed [PRIO_W-1:0] left_prio,
  input  logic [SK-1:0]            right_key,
  input  logic signed [PRIO_W-1:0] right_prio,
  output logic [SK-1:0]            key_q,
  output logic signed [PRIO_W-1:0] prio_q,
  output cell_stat_t               stat
);

  logic [SK-1:0]            key_r, key_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [SK-1:0]            req_key;

  assign req_key    = ctl.key[SK-1:0];
  assign stat.match = occ && (key_r == req_key);
  assign stat.ge    = occ && (prio_r >= ctl.prio);

  always_comb begin
    key_nxt  = key_r;
    prio_nxt = prio_r;
    if (ctl.ins_en) begin
      if (!stat.ge) begin
        // first cell below the new priority takes the new entry
        if (left_ge) begin
          key_nxt  = req_key;
          prio_nxt = ctl.prio;
        end else begin
          key_nxt  = left_key;
          prio_nxt = left_prio;
        end
      end
    end else if (ctl.rem_en && (ctl.rank <= RANK_W'(IDX))) begin
      key_nxt  = right_key;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prio_r <= prio_nxt;
  end

  assign key_q  = key_r;
  assign prio_q = prio_r;

endmodule

// ===== rtl/sorted_priority_task_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Keyed priority list kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one action: insert, remove at rank,
//   peek top or pop top. every action gives one result on out_valid/
//   out_stall/out_data with status, the entry read and the new count.
//   an item is taken into the request register; its result is then
//   registered in the output register, which drives out_valid, once
//   that register is free. the block takes no new item before that:
//   the request register is not refilled in the cycle its result is
//   registered; the cell row's compares and shifts resolve in that cycle.
//   in_stall is high while an item is held in the request register.
//   if the receiver stalls and a result still waits, the next item stays
//   in the request register until the output register frees up.
//   reset empties the list (count to zero); the cells hold no reset value
//   and are only read below the count.
//   equal priorities keep arrival order; a duplicate key is refused first,
//   then a full list.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int SK  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RCW = (CW > RANK_W) ? CW : RANK_W;

  logic            busy_r, busy_nxt;
  in_t             req_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            accept, fire;
  logic            dup, full, empty, rank_ok, ins_ok, rem_ok;
  logic [RANK_W-1:0] rank_eff;
  cell_ctl_t       ctl;

  logic [DEPTH-1:0]         occ;
  logic [DEPTH-1:0]         match_v, ge_v;
  logic [SK-1:0]            cell_key  [DEPTH];
  logic signed [PRIO_W-1:0] cell_prio [DEPTH];
  cell_stat_t               cell_stat [DEPTH];
  logic [SK-1:0]            sel_key;
  logic signed [PRIO_W-1:0] sel_prio;

  assign accept   = in_valid && !busy_r;
  assign fire     = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]     = (CW'(i) < count_r);
      match_v[i] = cell_stat[i].match;
      ge_v[i]    = cell_stat[i].ge;
    end
  end

  assign dup      = |match_v;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign rank_eff = (req_r.action == ACT_REMOVE) ? req_r.rank : '0;
  assign rank_ok  = (RCW'(rank_eff) < RCW'(count_r));
  assign ins_ok   = (req_r.action == ACT_INSERT) && !dup && !full;
  assign rem_ok   = ((req_r.action == ACT_REMOVE) || (req_r.action == ACT_POP)) && rank_ok;

  assign ctl.ins_en = fire && ins_ok;
  assign ctl.rem_en = fire && rem_ok;
  assign ctl.rank   = rank_eff;
  assign ctl.key    = req_r.key;
  assign ctl.prio   = req_r.priority_req;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     l_ge;
    logic [SK-1:0]            l_key, r_key;
    logic signed [PRIO_W-1:0] l_prio, r_prio;

    if (g == 0) begin : g_first
      assign l_ge   = 1'b1;
      assign l_key  = req_r.key[SK-1:0];
      assign l_prio = req_r.priority_req;
    end else begin : g_mid
      assign l_ge   = ge_v[g-1];
      assign l_key  = cell_key[g-1];
      assign l_prio = cell_prio[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_key  = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_key  = cell_key[g+1];
      assign r_prio = cell_prio[g+1];
    end

    spq_cell #(
      .IDX (g),
      .SK  (SK)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[g]),
      .left_ge    (l_ge),
      .left_key   (l_key),
      .left_prio  (l_prio),
      .right_key  (r_key),
      .right_prio (r_prio),
      .key_q      (cell_key[g]),
      .prio_q     (cell_prio[g]),
      .stat       (cell_stat[g])
    );
  end

  // read port: entry at the effective rank
  always_comb begin
    sel_key  = '0;
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rank_eff == RANK_W'(i)) begin
        sel_key  = sel_key | cell_key[i];
        sel_prio = sel_prio | cell_prio[i];
      end
    end
  end

  always_comb begin
    count_nxt            = count_r;
    out_nxt.status       = ST_OK;
    out_nxt.out_key      = '0;
    out_nxt.out_priority = '0;
    case (req_r.action)
      ACT_INSERT: begin
        if (dup) begin
          out_nxt.status = ST_DUP;
        end else if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (!rank_ok) begin
          out_nxt.status = ST_NOTFOUND;
        end else begin
          out_nxt.out_key      = KEY_W'(sel_key);
          out_nxt.out_priority = sel_prio;
          count_nxt            = count_r - CW'(1);
        end
      end
      ACT_PEEK, ACT_POP: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.out_key      = KEY_W'(sel_key);
          out_nxt.out_priority = sel_prio;
          if (req_r.action == ACT_POP) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
    out_nxt.entry_count = COUNT_W'(count_nxt);
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (fire) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // one item in flight: a transfer in closes the input for the next cycle
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.entry_count) <= DEPTH))
    else $error("entry count above depth");

  // failed actions carry no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |->
      ((out_data.out_key == '0) && (out_data.out_priority == '0)))
    else $error("failed action returned an entry");

endmodule

bind sorted_priority_task_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
